// File: hdl/amf_pkg.sv
`default_nettype none
package amf_pkg;

    // Payload widths of the stream channels.
    localparam int PIX_W      = 8;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Signed coordinate width and width of clamped frame limits.
    localparam int COORD_W = 14;
    localparam int LIM_W   = 13;
    // Window size register width (room for size plus two).
    localparam int WIN_W   = 5;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_ROW_BYTES    = 3'd0;
    localparam logic [2:0] REG_IMAGE_ROWS   = 3'd1;
    localparam logic [2:0] REG_CHANNEL_STEP = 3'd2;
    localparam logic [2:0] REG_MIN_WINDOW   = 3'd3;
    localparam logic [2:0] REG_MAX_WINDOW   = 3'd4;

    // Input kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// File: hdl/adaptive_median_pixel_filter.sv
`default_nettype none
// Adaptive median filter over a stored frame of 8-bit pixels.
// Input stream: tuser is the kind (0 writes a pixel, 1 queries one); tdata carries
// row, col and pixel_in. A write is stored in the cycle of its transfer, makes no
// result, and the block is ready again in the next cycle.
// A query makes one result on the output stream: filtered, window_used, exhausted.
// For each window size tried, the window is swept once per bit of the pixel:
// the first sweep finds the minimum, maximum and pixel count, and eight sweeps
// in all select the lower median one bit at a time. Each sweep visits the
// (2*h+1)^2 window cells with h = size/2 and reads the frame memory once for
// each cell inside the frame; cells outside it are skipped.
// A query outside the frame answers without a sweep.
// The input is not ready while a query is at work. The result waits in an output
// register until taken; a new query finishing while it waits stalls until then.
// Reset clears control and restores the register defaults; the frame memory is
// not cleared, and a pixel must be written before a query reads it.
// Registers sit on the APB-style port at byte addresses 0, 4, 8, 12 and 16.
module adaptive_median_pixel_filter #(
    parameter int MAX_ROWS      = 256,
    parameter int MAX_ROW_BYTES = 256,
    parameter int MAX_WINDOW    = 7
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Input stream.
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: row [7:0], col [15:8], pixel_in [23:16]
    input  wire  [amf_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: kind [0]
    input  wire                               i_s_axis_tuser,
    // Output stream.
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // tdata: filtered [7:0], window_used [10:8], exhausted [11], zero [15:12]
    output logic [amf_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // Configuration port.
    input  wire                               i_psel,
    input  wire                               i_penable,
    input  wire                               i_pwrite,
    input  wire  [amf_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  wire  [amf_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [amf_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                              o_pready
);
    import amf_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_ROW_BYTES;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

    // Configuration registers.
    logic [8:0] r_row_bytes;
    logic [8:0] r_image_rows;
    logic [1:0] r_step;
    logic [2:0] r_wmin;
    logic [2:0] r_wmax;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign o_pready = 1'b1;
    assign cfg_idx  = i_paddr[4:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes  <= 9'd256;
            r_image_rows <= 9'd256;
            r_step       <= 2'd1;
            r_wmin       <= 3'd3;
            r_wmax       <= 3'd7;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROW_BYTES:    r_row_bytes  <= i_pwdata[8:0];
                REG_IMAGE_ROWS:   r_image_rows <= i_pwdata[8:0];
                REG_CHANNEL_STEP: r_step       <= i_pwdata[1:0];
                REG_MIN_WINDOW:   r_wmin       <= i_pwdata[2:0];
                REG_MAX_WINDOW:   r_wmax       <= i_pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (cfg_idx)
            REG_ROW_BYTES:    o_prdata = APB_DATA_W'(r_row_bytes);
            REG_IMAGE_ROWS:   o_prdata = APB_DATA_W'(r_image_rows);
            REG_CHANNEL_STEP: o_prdata = APB_DATA_W'(r_step);
            REG_MIN_WINDOW:   o_prdata = APB_DATA_W'(r_wmin);
            REG_MAX_WINDOW:   o_prdata = APB_DATA_W'(r_wmax);
            default:          o_prdata = '0;
        endcase
    end

    // Effective frame limits and window bounds after clamping.
    logic [LIM_W-1:0] cols, rows;
    logic [1:0]       step;
    logic [WIN_W-1:0] wmin, wmax, wmax_c;

    always_comb begin
        if (r_row_bytes == 9'd0) begin
            cols = LIM_W'(1);
        end else if (LIM_W'(r_row_bytes) > LIM_W'(MAX_ROW_BYTES)) begin
            cols = LIM_W'(MAX_ROW_BYTES);
        end else begin
            cols = LIM_W'(r_row_bytes);
        end
        if (r_image_rows == 9'd0) begin
            rows = LIM_W'(1);
        end else if (LIM_W'(r_image_rows) > LIM_W'(MAX_ROWS)) begin
            rows = LIM_W'(MAX_ROWS);
        end else begin
            rows = LIM_W'(r_image_rows);
        end
        step = (r_step == 2'd0) ? 2'd1 : r_step;
        if (r_wmin == 3'd0) begin
            wmin = WIN_W'(1);
        end else if (WIN_W'(r_wmin) > WIN_W'(MAX_WINDOW)) begin
            wmin = WIN_W'(MAX_WINDOW);
        end else begin
            wmin = WIN_W'(r_wmin);
        end
        if (r_wmax == 3'd0) begin
            wmax_c = WIN_W'(1);
        end else if (WIN_W'(r_wmax) > WIN_W'(MAX_WINDOW)) begin
            wmax_c = WIN_W'(MAX_WINDOW);
        end else begin
            wmax_c = WIN_W'(r_wmax);
        end
        wmax = (wmax_c < wmin) ? wmin : wmax_c;
    end

    // Input fields.
    logic [7:0] in_row, in_col, in_pix;
    logic       in_xfer;

    assign in_row  = i_s_axis_tdata[7:0];
    assign in_col  = i_s_axis_tdata[15:8];
    assign in_pix  = i_s_axis_tdata[23:16];
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // Query and sweep state.
    t_state                    r_state, n_state;
    logic [7:0]                r_qr, r_qc;
    logic [WIN_W-1:0]          r_w;
    logic [WIN_W-1:0]          r_ia, r_ib;
    logic signed [COORD_W-1:0] r_rr, r_cc, r_cstart;
    logic [2:0]                r_bit;
    logic [PIX_W-1:0]          r_pref;
    logic [NW-1:0]             r_k, r_n, r_cnt0;
    logic [PIX_W-1:0]          r_min, r_max, r_centre;
    logic                      r_pend, r_pend_ctr;
    logic [PIX_W-1:0]          r_res;
    logic [WIN_W-1:0]          r_used;
    logic                      r_exh;

    // Output register.
    logic                      r_ovalid;
    logic [PIX_W-1:0]          r_ofilt;
    logic [2:0]                r_oused;
    logic                      r_oexh;

    logic [WIN_W-1:0]          h, span_last;
    logic                      cell_in_frame, is_ctr, row_end, last_cell;
    logic                      out_free, query_in_frame;

    assign h         = r_w >> 1;
    assign span_last = h << 1;
    assign row_end   = (r_ib == span_last);
    assign last_cell = row_end && (r_ia == span_last);
    assign is_ctr    = (r_ia == h) && (r_ib == h);
    assign cell_in_frame = (r_rr >= 0) && (r_rr < $signed(COORD_W'(rows)))
                           && (r_cc >= 0) && (r_cc < $signed(COORD_W'(cols)));
    assign out_free  = !r_ovalid || i_m_axis_tready;
    assign query_in_frame = (LIM_W'(in_row) < rows) && (LIM_W'(in_col) < cols);

    // Frame memory ports.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    assign ram_we = in_xfer && (i_s_axis_tuser == KIND_WRITE)
                    && (LIM_W'(in_row) < LIM_W'(MAX_ROWS))
                    && (LIM_W'(in_col) < LIM_W'(MAX_ROW_BYTES));
    assign ram_waddr = AW'(32'(in_row) * 32'(MAX_ROW_BYTES) + 32'(in_col));
    assign ram_re    = (r_state == S_SCAN) && cell_in_frame;
    assign ram_raddr = AW'(32'(unsigned'(r_rr)) * 32'(MAX_ROW_BYTES)
                           + 32'(unsigned'(r_cc)));

    amf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_pix),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Rank step at the end of a sweep.
    logic [NW-1:0]    kk;
    logic             take_zero;
    logic [PIX_W-1:0] new_pref;
    logic             med_ok, ctr_ok;

    assign kk        = (r_bit == 3'd7) ? ((r_n - NW'(1)) >> 1) : r_k;
    assign take_zero = kk < r_cnt0;
    assign new_pref  = take_zero ? r_pref : (r_pref | (PIX_W'(1) << r_bit));
    assign med_ok    = (new_pref > r_min) && (new_pref < r_max);
    assign ctr_ok    = (r_centre > r_min) && (r_centre < r_max);

    // Bit test of one pixel against the median prefix.
    logic [PIX_W-1:0] hi_mask;
    logic             pix_zero;

    assign hi_mask  = ~(8'hFF >> (3'd7 - r_bit));
    assign pix_zero = (((ram_rdata ^ r_pref) & hi_mask) == '0) && !ram_rdata[r_bit];

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and input ready.
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_xfer && (i_s_axis_tuser == KIND_QUERY)) begin
                    n_state = query_in_frame ? S_INIT : S_DONE;
                end
            end
            S_INIT:  n_state = S_SCAN;
            S_SCAN:  n_state = last_cell ? S_DRAIN : S_SCAN;
            S_DRAIN: n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_bit != 3'd0) begin
                    n_state = S_INIT;
                end else if (med_ok || (r_w + WIN_W'(2) > wmax)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Read-data tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= ram_re;
        end
    end

    // Sweep datapath.
    always_ff @(posedge i_clk) begin
        r_pend_ctr <= is_ctr;
        case (r_state)
            S_IDLE: begin
                r_qr   <= in_row;
                r_qc   <= in_col;
                r_w    <= wmin;
                r_bit  <= 3'd7;
                r_pref <= '0;
                r_res  <= '0;
                r_used <= '0;
                r_exh  <= 1'b1;
            end
            S_INIT: begin
                r_ia     <= '0;
                r_ib     <= '0;
                r_rr     <= $signed(COORD_W'(r_qr)) - $signed(COORD_W'(h));
                r_cc     <= $signed(COORD_W'(r_qc)) - $signed(COORD_W'(h) * COORD_W'(step));
                r_cstart <= $signed(COORD_W'(r_qc)) - $signed(COORD_W'(h) * COORD_W'(step));
                r_cnt0   <= '0;
                if (r_bit == 3'd7) begin
                    r_n   <= '0;
                    r_min <= '1;
                    r_max <= '0;
                end
            end
            S_SCAN: begin
                if (row_end) begin
                    r_ib <= '0;
                    r_ia <= r_ia + WIN_W'(1);
                    r_cc <= r_cstart;
                    r_rr <= r_rr + COORD_W'(1);
                end else begin
                    r_ib <= r_ib + WIN_W'(1);
                    r_cc <= r_cc + $signed(COORD_W'(step));
                end
            end
            S_DECIDE: begin
                r_k    <= take_zero ? kk : (kk - r_cnt0);
                r_pref <= new_pref;
                if (r_bit != 3'd0) begin
                    r_bit <= r_bit - 3'd1;
                end else begin
                    r_used <= r_w;
                    if (med_ok) begin
                        r_res <= ctr_ok ? r_centre : new_pref;
                        r_exh <= 1'b0;
                    end else begin
                        r_res  <= new_pref;
                        r_w    <= r_w + WIN_W'(2);
                        r_bit  <= 3'd7;
                        r_pref <= '0;
                    end
                end
            end
            default: ;
        endcase
        // Accumulate the pixel read in the previous cycle.
        if (r_pend) begin
            if (pix_zero) begin
                r_cnt0 <= r_cnt0 + NW'(1);
            end
            if (r_bit == 3'd7) begin
                r_n <= r_n + NW'(1);
                if (ram_rdata < r_min) begin
                    r_min <= ram_rdata;
                end
                if (ram_rdata > r_max) begin
                    r_max <= ram_rdata;
                end
                if (r_pend_ctr) begin
                    r_centre <= ram_rdata;
                end
            end
        end
    end

    // Output register: loaded when a query finishes, cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_ofilt <= r_res;
            r_oused <= r_used[2:0];
            r_oexh  <= r_exh;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {4'b0000, r_oexh, r_oused, r_ofilt};

    // Read data only follows a sweep cycle.
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == S_SCAN))
        else $error("read data without a sweep read");

    // The centre pixel is always inside the frame, so a sweep counts at least one.
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_n != '0))
        else $error("empty window at decision");

    // The bit count never exceeds the pixel count.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_cnt0 <= r_n))
        else $error("bit count above pixel count");

    // A decided result names the window it came from.
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_oexh) |-> (r_oused != 3'd0))
        else $error("decided result without window size");

endmodule
`default_nettype wire

// File: hdl/amf_ram.sv
`default_nettype none
module amf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                      i_wdata,
    input  wire                                   i_re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amf_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // tdata: row [7:0], col [15:8], pixel_in [23:16]
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    // tuser: kind [0]
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // tdata: filtered [7:0], window_used [10:8], exhausted [11], zero [15:12]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [APB_ADDR_W-1:0] i_paddr;
    logic [APB_DATA_W-1:0] i_pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    adaptive_median_pixel_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    // Shadow copy of the frame store and of the registers.
    logic [7:0]  frame_px [65536];
    bit          px_written [65536];
    logic [8:0]  cfg_row_bytes;
    logic [8:0]  cfg_image_rows;
    logic [1:0]  cfg_step;
    logic [2:0]  cfg_wmin;
    logic [2:0]  cfg_wmax;

    // Expected results: {exhausted, window_used, filtered}.
    logic [11:0] pending_results [$];
    int          mismatches;
    int          accepted_items;
    int          burst_left;
    int          hold_cycles;
    int          stall_mode;
    int          rx_cycle;

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Registers as the filter sees them after clamping.
    function automatic void frame_limits(output int rows, output int cols, output int step,
                                         output int wmin, output int wmax);
        cols = (cfg_row_bytes == 0) ? 1 : (cfg_row_bytes > 256) ? 256 : int'(cfg_row_bytes);
        rows = (cfg_image_rows == 0) ? 1 : (cfg_image_rows > 256) ? 256 : int'(cfg_image_rows);
        step = (cfg_step == 0) ? 1 : int'(cfg_step);
        wmin = (cfg_wmin == 0) ? 1 : int'(cfg_wmin);
        wmax = (cfg_wmax == 0) ? 1 : int'(cfg_wmax);
        if (wmax < wmin) wmax = wmin;
    endfunction

    // Adaptive median decision for one queried pixel.
    function automatic logic [11:0] filter_pixel(int r, int c);
        int rows, cols, step, wmin, wmax;
        int w, h, a, b, rr, cc, n, k, acc, mn, mx, med, centre, used;
        int hist [256];
        logic [7:0] res;
        bit exh;
        frame_limits(rows, cols, step, wmin, wmax);
        res = 0;
        used = 0;
        exh = 1'b1;
        if (r < rows && c < cols) begin
            centre = frame_px[r * 256 + c];
            for (w = wmin; w <= wmax; w += 2) begin
                foreach (hist[i]) hist[i] = 0;
                h = w / 2;
                n = 0;
                for (a = -h; a <= h; a++) begin
                    rr = r + a;
                    if (rr < 0 || rr >= rows) continue;
                    for (b = -h; b <= h; b++) begin
                        cc = c + b * step;
                        if (cc < 0 || cc >= cols) continue;
                        hist[frame_px[rr * 256 + cc]]++;
                        n++;
                    end
                end
                mn = 0;
                mx = 0;
                med = 0;
                for (int v = 0; v < 256; v++) if (hist[v] != 0) begin mn = v; break; end
                for (int v = 255; v >= 0; v--) if (hist[v] != 0) begin mx = v; break; end
                k = (n - 1) / 2;
                acc = 0;
                for (int v = 0; v < 256; v++) begin
                    acc += hist[v];
                    if (acc > k) begin med = v; break; end
                end
                used = w;
                if (med > mn && med < mx) begin
                    res = (centre > mn && centre < mx) ? centre[7:0] : med[7:0];
                    exh = 1'b0;
                    break;
                end
                res = med[7:0];
            end
        end
        return {exh, used[2:0], res};
    endfunction

    // Mostly mid-gray values with salt and pepper noise mixed in.
    function automatic logic [7:0] noisy_pixel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return 8'($urandom_range(0, 255));
            default: return 8'(100 + $urandom_range(0, 20));
        endcase
    endfunction

    // Offers one item and waits for its transfer; called at a falling edge.
    task automatic send_item(logic kind, int r, int c, logic [7:0] px);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tuser = kind;
        i_s_axis_tdata = {px, 8'(c), 8'(r)};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind == KIND_WRITE) begin
            frame_px[r * 256 + c] = px;
            px_written[r * 256 + c] = 1'b1;
        end else begin
            pending_results = {pending_results, filter_pixel(r, c)};
        end
        accepted_items++;
        @(negedge i_clk);
    endtask

    // Writes every unwritten pixel the query may read, then queries.
    task automatic query_pixel(int r, int c);
        int rows, cols, step, wmin, wmax, rr, cc;
        frame_limits(rows, cols, step, wmin, wmax);
        if (r < rows && c < cols) begin
            for (int a = -3; a <= 3; a++) begin
                for (int b = -3; b <= 3; b++) begin
                    rr = r + a;
                    cc = c + b * step;
                    if (rr < 0 || rr >= rows || cc < 0 || cc >= cols) continue;
                    if (!px_written[rr * 256 + cc]) send_item(KIND_WRITE, rr, cc, noisy_pixel());
                end
            end
        end
        send_item(KIND_QUERY, r, c, 8'($urandom_range(0, 255)));
    endtask

    // Waits until every result has come and the block has gone quiet.
    task automatic settle_idle();
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        i_psel = 1'b1;
        i_pwrite = 1'b1;
        i_penable = 1'b0;
        i_paddr = {idx, 2'b00};
        i_pwdata = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(negedge i_clk);
        i_psel = 1'b0;
        i_penable = 1'b0;
        case (idx)
            REG_ROW_BYTES:    cfg_row_bytes = value[8:0];
            REG_IMAGE_ROWS:   cfg_image_rows = value[8:0];
            REG_CHANNEL_STEP: cfg_step = value[1:0];
            REG_MIN_WINDOW:   cfg_wmin = value[2:0];
            REG_MAX_WINDOW:   cfg_wmax = value[2:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [31:0] rb, logic [31:0] ir, logic [31:0] st,
                                logic [31:0] wlo, logic [31:0] whi);
        settle_idle();
        apb_write(REG_ROW_BYTES, rb);
        apb_write(REG_IMAGE_ROWS, ir);
        apb_write(REG_CHANNEL_STEP, st);
        apb_write(REG_MIN_WINDOW, wlo);
        apb_write(REG_MAX_WINDOW, whi);
    endtask

    // Reset defaults: full 256 x 256 frame, corners and an inner pixel.
    task automatic test_defaults();
        query_pixel(0, 0);
        query_pixel(255, 255);
        query_pixel(128, 7);
    endtask

    // Small frames, edges, RGB step, even sizes and an inverted window range.
    task automatic test_geometry();
        apply_config(9, 6, 1, 1, 7);
        query_pixel(0, 0);
        query_pixel(5, 8);
        query_pixel(3, 4);
        apply_config(12, 5, 3, 2, 6);
        query_pixel(2, 4);
        query_pixel(4, 11);
        apply_config(12, 5, 2, 7, 1);
        query_pixel(2, 5);
        apply_config(1, 1, 1, 1, 1);
        query_pixel(0, 0);
    endtask

    // Values outside the legal ranges, with junk in the unused upper bits.
    task automatic test_register_limits();
        apply_config(32'hFFFF_FE00, 32'h0000_012C, 32'hFFFF_FFFC, 32'hFFFF_FFF8, 32'h0);
        query_pixel(0, 0);
        query_pixel(200, 0);
        apply_config(32'h0000_01FF, 32'h0000_0003, 32'h0, 32'h0, 32'h0000_0007);
        query_pixel(1, 40);
    endtask

    // Queries past the right and bottom edges of the frame, and at its last inside corner.
    task automatic test_outside_frame();
        apply_config(20, 10, 1, 3, 5);
        query_pixel(10, 0);
        query_pixel(0, 20);
        query_pixel(255, 255);
        query_pixel(9, 19);
    endtask

    // Receiver holds off for a long stretch while queries keep coming.
    task automatic test_backpressure();
        apply_config(16, 8, 1, 1, 3);
        hold_cycles = 4000;
        for (int i = 0; i < 6; i++) query_pixel($urandom_range(0, 7), $urandom_range(0, 15));
    endtask

    // Random phases, each under a random configuration (phase 2 with full row width, phase 4 with full height).
    task automatic test_random();
        int rows, cols, step, wmin, wmax, goal;
        for (int phase = 0; phase < 6; phase++) begin
            apply_config((phase == 2) ? 256 : $urandom_range(1, 40),
                         (phase == 4) ? 256 : $urandom_range(1, 24),
                         $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7));
            frame_limits(rows, cols, step, wmin, wmax);
            goal = accepted_items + 165;
            while (accepted_items < goal) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                        query_pixel($urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
                    4:
                        query_pixel($urandom_range(0, 255), $urandom_range(0, 255));
                    5:
                        send_item(KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                                  8'($urandom_range(0, 255)));
                    default:
                        send_item(KIND_WRITE, $urandom_range(0, rows - 1),
                                  $urandom_range(0, cols - 1), noisy_pixel());
                endcase
            end
        end
    endtask

    // Receiver: long hold when asked, otherwise a changing stall pattern.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0) stall_mode <= $urandom_range(0, 2);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_axis_tready <= rx_cycle[2];
            endcase
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        logic [11:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: tdata=%h", o_m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[7:0] !== want[7:0] || o_m_axis_tdata[10:8] !== want[10:8]
                    || o_m_axis_tdata[11] !== want[11] || o_m_axis_tdata[15:12] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Result mismatch: filtered %0d/%0d used %0d/%0d ",
                                  "exh %0d/%0d (exp/act), pad %h"},
                                 want[7:0], o_m_axis_tdata[7:0], want[10:8],
                                 o_m_axis_tdata[10:8], want[11], o_m_axis_tdata[11],
                                 o_m_axis_tdata[15:12]);
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_m_axis_tready = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        mismatches = 0;
        accepted_items = 0;
        burst_left = 0;
        hold_cycles = 0;
        stall_mode = 0;
        rx_cycle = 0;
        cfg_row_bytes = 9'd256;
        cfg_image_rows = 9'd256;
        cfg_step = 2'd1;
        cfg_wmin = 3'd3;
        cfg_wmax = 3'd7;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_defaults();
        test_geometry();
        test_register_limits();
        test_outside_frame();
        test_backpressure();
        test_random();
        settle_idle();
        repeat (50) @(negedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
hdl/amf_pkg.sv
hdl/amf_ram.sv
hdl/adaptive_median_pixel_filter.sv
verif/tb_top.sv
